FILE: design/hrs_pkg.sv
// Package: sequencer states, ASCII codes and constants for the size formatter.
`default_nettype none
package hrs_pkg;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL1   = 7'b0000010,
    S_MUL2   = 7'b0000100,
    S_SEARCH = 7'b0001000,
    S_PRE    = 7'b0010000,
    S_DIGIT  = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  typedef enum logic {
    MODE_WHOLE  = 1'b0,
    MODE_TENTHS = 1'b1
  } fmt_mode_t;

  localparam int unsigned COUNT_W = 60;
  localparam int unsigned PROD_W  = 67;   // count * 100 < 2^67
  localparam int unsigned VAL_W   = 17;   // scaled hundredths < 2^17
  localparam int unsigned LVL_W   = 3;

  localparam logic [COUNT_W-1:0] SMALL_LIMIT = COUNT_W'(1000);
  localparam logic [VAL_W-1:0]   TENTHS_LIM  = VAL_W'(995);
  localparam logic [VAL_W-1:0]   WHOLE_MAX   = VAL_W'(999);
  localparam logic [VAL_W-1:0]   HALF_WHOLE  = VAL_W'(50);
  localparam logic [VAL_W-1:0]   HALF_TENTH  = VAL_W'(5);
  localparam logic [LVL_W-1:0]   LEVEL_MAX   = LVL_W'(6);
  localparam logic [LVL_W-1:0]   LEVEL_P     = LVL_W'(5);

  // ceil(2^20 / 10): exact floor(x / 10) for x < 2^18
  localparam logic [VAL_W-1:0]   DIV10_RECIP = VAL_W'(104858);
  localparam int unsigned        DIV10_SHIFT = 20;

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_ONE   = 8'h31;
  localparam logic [7:0] ASCII_B     = 8'h42;
  localparam logic [7:0] ASCII_K     = 8'h4B;
  localparam logic [7:0] ASCII_M     = 8'h4D;
  localparam logic [7:0] ASCII_G     = 8'h47;
  localparam logic [7:0] ASCII_T     = 8'h54;
  localparam logic [7:0] ASCII_P     = 8'h50;
  localparam logic [7:0] ASCII_NUL   = 8'h00;

  function automatic logic [7:0] unit_char(input logic [LVL_W-1:0] level);
    logic [7:0] c;
    case (level)
      3'd0:    c = ASCII_B;
      3'd1:    c = ASCII_K;
      3'd2:    c = ASCII_M;
      3'd3:    c = ASCII_G;
      3'd4:    c = ASCII_T;
      3'd5:    c = ASCII_P;
      default: c = ASCII_NUL;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/hrs_if.sv
// Handshake interfaces: byte-count request channel and size-text result channel.
`default_nettype none
interface hrs_req_if;
  logic        valid;
  logic        ready;
  logic [59:0] byte_count;

  modport source (output valid, output byte_count, input ready);
  modport sink   (input valid, input byte_count, output ready);
endinterface

interface hrs_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_first;
  logic [7:0] char_second;
  logic [7:0] char_third;
  logic [7:0] char_unit;
  logic       out_of_range;

  modport source (output valid, output char_first, output char_second,
                  output char_third, output char_unit, output out_of_range,
                  input ready);
  modport sink   (input valid, input char_first, input char_second,
                  input char_third, input char_unit, input out_of_range,
                  output ready);
endinterface
`default_nettype wire

FILE: design/human_readable_size_formatter.sv
// Top level: byte count to four-character binary-prefix size text.
//
//  channel   dir  payload                                        handshake
//  request   in   byte_count[59:0]                               valid/ready
//  result    out  char_first/second/third/unit[7:0], out_of_range valid/ready
//
// One item at a time: request.ready high only while idle. A count below 1000
// goes straight to the digit state; a larger one passes through the two multiply
// states, the prefix search (1..6 shift steps), the divider pre-pass and the digit
// state, or from the pre-pass to the finish state on a carry to "1.0", plus any wait for the result register.
// Reset (rst, synchronous) empties the sequencer and the result register.
// A finished text waits in the sequencer, blocking requests, only while the
// result register is still full.
`default_nettype none
module human_readable_size_formatter
  import hrs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  hrs_req_if.sink     request,
  hrs_res_if.source   result
);

  state_t                state;
  fmt_mode_t             mode;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    quot;     // count >> 10*level
  logic [PROD_W-1:0]     prod;     // (count * 100) >> 10*level
  logic [LVL_W-1:0]      level;
  logic [VAL_W-1:0]      x;        // operand of the divide-by-ten unit
  logic                  pre_last;
  logic [1:0]            pos;
  logic [7:0]            chr [3];

  logic                  res_valid;
  logic [7:0]            res_first, res_second, res_third, res_unit;
  logic                  res_oor;

  // shared divide-by-ten unit: reciprocal multiply, remainder by shift-add
  logic [2*VAL_W-1:0]    div_mul;
  logic [VAL_W-1:0]      dq;
  logic [VAL_W-1:0]      dq10;
  logic [VAL_W-1:0]      drem;
  logic [3:0]            dr;

  always_comb begin
    div_mul = {{VAL_W{1'b0}}, x} * {{VAL_W{1'b0}}, DIV10_RECIP};
    dq      = VAL_W'(div_mul[2*VAL_W-1:DIV10_SHIFT]);
    dq10    = (dq << 3) + (dq << 1);
    drem    = x - dq10;
    dr      = drem[3:0];
  end

  logic [PROD_W-1:0] count_w;
  logic [VAL_W-1:0]  v;
  logic              res_free;

  assign count_w  = {{(PROD_W-COUNT_W){1'b0}}, count};
  assign v        = prod[VAL_W-1:0];
  assign res_free = !res_valid || result.ready;

  assign request.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // result register: loaded from the finish state, emptied by the sink
      if (state == S_FIN && res_free) res_valid <= 1'b1;
      else if (result.ready)          res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (request.valid) begin
            count <= request.byte_count;
            quot  <= request.byte_count;
            level <= '0;
            if (request.byte_count < SMALL_LIMIT) begin
              // plain bytes: right-aligned digits, 'B'
              x     <= request.byte_count[VAL_W-1:0];
              mode  <= MODE_WHOLE;
              pos   <= 2'd2;
              state <= S_DIGIT;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          prod  <= (count_w << 6) + (count_w << 5);
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod  <= prod + (count_w << 2);
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (quot >= SMALL_LIMIT && level < LEVEL_MAX) begin
            quot  <= quot >> 10;
            prod  <= prod >> 10;
            level <= level + LVL_W'(1);
          end else if (v >= TENTHS_LIM) begin
            // whole number: w = (v + 50) / 100, two passes of the divider
            x        <= v + HALF_WHOLE;
            mode     <= MODE_WHOLE;
            pre_last <= 1'b0;
            state    <= S_PRE;
          end else begin
            // d.d: t = (v + 5) / 10
            x        <= v + HALF_TENTH;
            mode     <= MODE_TENTHS;
            pre_last <= 1'b1;
            state    <= S_PRE;
          end
        end
        S_PRE: begin
          pre_last <= 1'b1;
          if (pre_last) begin
            if (mode == MODE_WHOLE && dq > WHOLE_MAX) begin
              // rounding carried to 1000: "1.0" with the next prefix
              chr[0] <= ASCII_ONE;
              chr[1] <= ASCII_DOT;
              chr[2] <= ASCII_ZERO;
              level  <= level + LVL_W'(1);
              state  <= S_FIN;
            end else begin
              x     <= dq;
              pos   <= 2'd2;
              state <= S_DIGIT;
            end
          end else begin
            x <= dq;
          end
        end
        S_DIGIT: begin
          if (mode == MODE_TENTHS && pos == 2'd1) begin
            chr[pos] <= ASCII_DOT;
          end else begin
            // last place is always a digit, leading zeros become spaces
            if (pos == 2'd2 || x != '0) chr[pos] <= ASCII_ZERO + {4'd0, dr};
            else                        chr[pos] <= ASCII_SPACE;
            x <= dq;
          end
          if (pos == 2'd0) state <= S_FIN;
          else             pos   <= pos - 2'd1;
        end
        S_FIN: begin
          if (res_free) begin
            res_first  <= chr[0];
            res_second <= chr[1];
            res_third  <= chr[2];
            res_unit   <= unit_char(level);
            res_oor    <= (level > LEVEL_P);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid        = res_valid;
  assign result.char_first   = res_first;
  assign result.char_second  = res_second;
  assign result.char_third   = res_third;
  assign result.char_unit    = res_unit;
  assign result.out_of_range = res_oor;

endmodule
`default_nettype wire
